FILE: hdl/abp_pkg.sv
// Shared constants, types and arithmetic helpers for the binomial option pricer.
package abp_pkg;

    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 2);
    localparam int VAW       = $clog2(MAX_STEPS + 1);
    localparam int TRI_DEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
    localparam int TRI_AW    = $clog2(TRI_DEPTH);
    localparam int CFG_IW    = 3;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic [CFG_IW-1:0] REG_UP_FACTOR    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DOWN_FACTOR  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PROB_UP      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_STEP_DISCNT  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_STEPS        = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_ROLL,
        ST_FINAL,
        ST_EMIT
    } abp_state_t;

    typedef struct packed {
        logic              valid;
        logic [TRI_AW-1:0] taddr;
        logic              vwrite;
        logic [VAW-1:0]    vaddr;
        logic [31:0]       ex;
    } lat_wr_t;

    typedef struct packed {
        logic busy;
        logic sat;
    } lat_stat_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } mul_res_t;

    function automatic mul_res_t mul_q30(input logic [31:0] a, input logic [31:0] f);
        logic [63:0] prod;
        mul_res_t    r;
        prod  = {32'd0, a} * {32'd0, f};
        r.sat = |prod[63:62];
        r.val = r.sat ? 32'hFFFF_FFFF : prod[61:30];
        return r;
    endfunction

    function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                              input logic put);
        logic [31:0] r;
        if (put)
        begin
            r = (k > s) ? k - s : 32'd0;
        end
        else
        begin
            r = (s > k) ? s - k : 32'd0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/american_option_binomial_pricer.sv
// Top level: American option pricer on a binomial tree held in on-chip memories.
// The forward pass is bound by one saturating multiply per lattice node; the rollback by one
// value-memory read per node plus one priming read and a drain of the s1-s3 pipeline at each level.
// One item is in flight at a time; the next is taken once the result enters the output register.
// Reset clears control and restores register defaults; the node memories are not cleared.
module american_option_binomial_pricer
    import abp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // spot_price[31:0], strike_price[63:32]
    input  logic [0:0]        s_axis_tuser,   // is_put[0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // option_value[31:0]
    output logic [0:0]        m_axis_tuser,   // saturated[0]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data
);

    abp_state_t        state_reg;
    abp_state_t        state_next;

    logic [31:0]       up_reg;
    logic [30:0]       down_reg;
    logic [30:0]       prob_reg;
    logic [30:0]       disc_reg;
    logic [6:0]        steps_reg;

    logic [31:0]       vmem [MAX_STEPS+1];
    logic [31:0]       tmem [TRI_DEPTH];
    logic [31:0]       vmem_rdata_reg;
    logic [31:0]       tmem_rdata_reg;
    logic [VAW-1:0]    vmem_raddr;
    logic [TRI_AW-1:0] tmem_raddr;
    logic              vmem_we;
    logic [VAW-1:0]    vmem_waddr;
    logic [31:0]       vmem_wdata;

    logic [STEP_W-1:0] n_steps;
    logic [30:0]       p_clamp;
    logic              accept;
    logic              lat_start;
    lat_wr_t           lat_wr;
    lat_stat_t         lat_stat;

    logic [STEP_W-1:0] t_reg;
    logic [STEP_W-1:0] j_reg;
    logic [TRI_AW-1:0] rbase_reg;
    logic              issue;
    logic              level_end;
    logic              roll_start;
    logic              out_free;
    logic              out_load;
    logic [2*STEP_W-1:0] nsq;

    logic              s1_v_reg;
    logic              s1_first_reg;
    logic [VAW-1:0]    s1_k_reg;
    logic [31:0]       vprev_reg;
    logic              s2_v_reg;
    logic signed [62:0] s2_prod_reg;
    logic [31:0]       s2_vold_reg;
    logic [31:0]       s2_ex_reg;
    logic [VAW-1:0]    s2_k_reg;
    logic              s3_v_reg;
    logic [31:0]       s3_cont_reg;
    logic [31:0]       s3_ex_reg;
    logic [VAW-1:0]    s3_k_reg;

    logic signed [32:0] delta;
    logic signed [64:0] prod_full;
    logic signed [33:0] cont_full;
    mul_res_t           disc_mr;
    logic [31:0]        roll_val;

    logic              sat_reg;
    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    logic              out_sat_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg    <= 32'h4000_0000;
            down_reg  <= Q30_ONE;
            prob_reg  <= 31'h2000_0000;
            disc_reg  <= Q30_ONE;
            steps_reg <= 7'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UP_FACTOR:   up_reg    <= cfg_data;
                REG_DOWN_FACTOR: down_reg  <= cfg_data[30:0];
                REG_PROB_UP:     prob_reg  <= cfg_data[30:0];
                REG_STEP_DISCNT: disc_reg  <= cfg_data[30:0];
                REG_STEPS:       steps_reg <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    assign n_steps = (32'(steps_reg) > 32'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(steps_reg);
    assign p_clamp = (prob_reg > Q30_ONE) ? Q30_ONE : prob_reg;
    assign nsq     = {{STEP_W{1'b0}}, n_steps} * {{STEP_W{1'b0}}, n_steps - STEP_W'(1)};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    abp_lattice u_lattice (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (lat_start),
        .spot_price   (s_axis_tdata[31:0]),
        .strike_price (s_axis_tdata[63:32]),
        .is_put       (s_axis_tuser[0]),
        .n_steps      (n_steps),
        .up_factor    (up_reg),
        .down_factor  (down_reg),
        .wr           (lat_wr),
        .stat         (lat_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lat_start  = 1'b0;
        issue      = 1'b0;
        level_end  = 1'b0;
        roll_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lat_start  = 1'b1;
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                if (!lat_stat.busy)
                begin
                    roll_start = 1'b1;
                    state_next = (n_steps == '0) ? ST_FINAL : ST_ROLL;
                end
            end
            ST_ROLL:
            begin
                issue = (j_reg <= t_reg);
                if (!issue && !s1_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    level_end = 1'b1;
                    if (t_reg == STEP_W'(1))
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg        <= '0;
            j_reg        <= '0;
            rbase_reg    <= '0;
            s1_v_reg     <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_k_reg     <= '0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            if (roll_start)
            begin
                t_reg     <= n_steps;
                j_reg     <= '0;
                rbase_reg <= TRI_AW'(nsq >> 1);
            end
            else if (level_end)
            begin
                t_reg     <= t_reg - STEP_W'(1);
                j_reg     <= '0;
                rbase_reg <= rbase_reg - TRI_AW'(t_reg - STEP_W'(1));
            end
            else if (issue)
            begin
                j_reg <= j_reg + STEP_W'(1);
            end

            s1_v_reg     <= issue;
            s1_first_reg <= (j_reg == '0);
            s1_k_reg     <= VAW'(j_reg - STEP_W'(1));
            s2_v_reg     <= s1_v_reg && !s1_first_reg;
            s3_v_reg     <= s2_v_reg;

            if (lat_start)
            begin
                sat_reg <= 1'b0;
            end
            else if (s3_v_reg)
            begin
                sat_reg <= sat_reg | disc_mr.sat;
            end
        end
    end

    assign delta     = $signed({1'b0, vmem_rdata_reg}) - $signed({1'b0, vprev_reg});
    assign prod_full = delta * $signed({1'b0, p_clamp});
    assign cont_full = $signed({2'b00, s2_vold_reg}) + 34'(s2_prod_reg >>> 30);
    assign disc_mr   = mul_q30(s3_cont_reg, {1'b0, disc_reg});
    assign roll_val  = (disc_mr.val > s3_ex_reg) ? disc_mr.val : s3_ex_reg;

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            vprev_reg   <= vmem_rdata_reg;
            s2_prod_reg <= prod_full[62:0];
            s2_vold_reg <= vprev_reg;
            s2_ex_reg   <= tmem_rdata_reg;
            s2_k_reg    <= s1_k_reg;
        end
        if (s2_v_reg)
        begin
            s3_cont_reg <= cont_full[31:0];
            s3_ex_reg   <= s2_ex_reg;
            s3_k_reg    <= s2_k_reg;
        end
    end

    always_comb
    begin
        if (state_reg == ST_FWD)
        begin
            vmem_we    = lat_wr.vwrite;
            vmem_waddr = lat_wr.vaddr;
            vmem_wdata = lat_wr.ex;
        end
        else
        begin
            vmem_we    = s3_v_reg;
            vmem_waddr = s3_k_reg;
            vmem_wdata = roll_val;
        end
    end

    assign vmem_raddr = (state_reg == ST_ROLL) ? j_reg[VAW-1:0] : '0;
    assign tmem_raddr = rbase_reg + TRI_AW'(j_reg) - TRI_AW'(1);

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= vmem_wdata;
        end
        vmem_rdata_reg <= vmem[vmem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lat_wr.valid)
        begin
            tmem[lat_wr.taddr] <= lat_wr.ex;
        end
        tmem_rdata_reg <= tmem[tmem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= vmem_rdata_reg;
            out_sat_reg   <= sat_reg | lat_stat.sat;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_sat_reg;

endmodule

FILE: hdl/abp_lattice.sv
// Forward lattice generator: walks the price tree diagonal by diagonal, emitting exercise values.
module abp_lattice
    import abp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       spot_price,
    input  logic [31:0]       strike_price,
    input  logic              is_put,
    input  logic [STEP_W-1:0] n_steps,
    input  logic [31:0]       up_factor,
    input  logic [30:0]       down_factor,
    output lat_wr_t           wr,
    output lat_stat_t         stat
);

    logic              busy_reg;
    logic              sat_reg;
    logic [STEP_W-1:0] m_reg;
    logic [STEP_W-1:0] k_reg;
    logic [TRI_AW-1:0] taddr_reg;
    logic [TRI_AW-1:0] dstart_reg;
    logic [31:0]       price_reg;
    logic [31:0]       dprice_reg;
    logic [31:0]       strike_reg;
    logic              put_reg;

    logic              diag_end;
    logic              tree_end;
    logic [31:0]       mul_a;
    logic [31:0]       mul_f;
    mul_res_t          mr;
    logic [STEP_W:0]   t_sum;
    logic [TRI_AW-1:0] dstart_next;

    assign diag_end    = (k_reg == (n_steps - m_reg));
    assign tree_end    = diag_end && (m_reg == n_steps);
    assign mul_a       = diag_end ? dprice_reg : price_reg;
    assign mul_f       = diag_end ? {1'b0, down_factor} : up_factor;
    assign mr          = mul_q30(mul_a, mul_f);
    assign t_sum       = {1'b0, m_reg} + {1'b0, k_reg};
    assign dstart_next = dstart_reg + TRI_AW'(m_reg) + TRI_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
            m_reg    <= '0;
            k_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            sat_reg  <= 1'b0;
            m_reg    <= '0;
            k_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (tree_end)
            begin
                busy_reg <= 1'b0;
            end
            else if (diag_end)
            begin
                m_reg   <= m_reg + STEP_W'(1);
                k_reg   <= '0;
                sat_reg <= sat_reg | mr.sat;
            end
            else
            begin
                k_reg   <= k_reg + STEP_W'(1);
                sat_reg <= sat_reg | mr.sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            price_reg  <= spot_price;
            dprice_reg <= spot_price;
            taddr_reg  <= '0;
            dstart_reg <= '0;
            strike_reg <= strike_price;
            put_reg    <= is_put;
        end
        else if (busy_reg && !tree_end)
        begin
            if (diag_end)
            begin
                price_reg  <= mr.val;
                dprice_reg <= mr.val;
                dstart_reg <= dstart_next;
                taddr_reg  <= dstart_next;
            end
            else
            begin
                price_reg <= mr.val;
                taddr_reg <= taddr_reg + TRI_AW'(t_sum) + TRI_AW'(2);
            end
        end
    end

    assign wr.valid  = busy_reg;
    assign wr.taddr  = taddr_reg;
    assign wr.vwrite = busy_reg && diag_end;
    assign wr.vaddr  = k_reg[VAW-1:0];
    assign wr.ex     = intrinsic(price_reg, strike_reg, put_reg);

    assign stat.busy = busy_reg;
    assign stat.sat  = sat_reg;

endmodule
